### hdl/rci_pkg.sv
// Shared constants for the ray against upright cylinder unit.
// No dependencies; imported by ray_cylinder_intersect_unit.
`timescale 1ns / 1ps
`default_nettype none

package rci_pkg;

  // default number format, signed Q16.16 in 32 bits
  localparam int unsigned RCI_FRAC_BITS   = 16;
  localparam int unsigned RCI_COORD_WIDTH = 32;

  // register index decode, taken from the word address
  localparam int unsigned RCI_IDX_W = 3;
  localparam logic [RCI_IDX_W-1:0] REG_CENTER_X     = 3'd0;
  localparam logic [RCI_IDX_W-1:0] REG_CENTER_Y     = 3'd1;
  localparam logic [RCI_IDX_W-1:0] REG_CENTER_Z     = 3'd2;
  localparam logic [RCI_IDX_W-1:0] REG_RADIUS       = 3'd3;
  localparam logic [RCI_IDX_W-1:0] REG_FULL_HEIGHT  = 3'd4;
  localparam logic [RCI_IDX_W-1:0] REG_MIN_DISTANCE = 3'd5;

  // reset value of min_distance in raw units
  localparam int unsigned RCI_MIN_DIST_RST = 66;

endpackage : rci_pkg

`default_nettype wire

### hdl/ray_cylinder_intersect_unit.sv
// Ray against finite cylinder (axis along y), fully pipelined.
// Depends on rci_pkg for defaults and register indexes.
//
//  channel   | dir | fields (low bit up)
//  ----------+-----+-----------------------------------------------------
//  s_axis    | in  | tdata: origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
//  m_axis    | out | tdata: distance   tuser: hit
//  apb       | in  | center_x/y/z, radius, full_height, min_distance
//
// One ray per cycle while the output is not stalled. Stages in order:
// five stages of quadratic setup, one discriminant stage, one stage per
// root bit of the square root, a numerator stage, one stage per quotient
// bit of the two dividers, then clamp, scaled y and the height test register.
// Reset clears valid bits and loads register defaults.
// A stalled output freezes the whole pipeline; nothing is dropped.
`timescale 1ns / 1ps
`default_nettype none

module ray_cylinder_intersect_unit
  import rci_pkg::*;
#(
  parameter int unsigned FRAC_BITS   = RCI_FRAC_BITS,
  parameter int unsigned COORD_WIDTH = RCI_COORD_WIDTH,
  localparam int unsigned IN_W  = ((6 * COORD_WIDTH + 7) / 8) * 8,
  localparam int unsigned OUT_W = ((COORD_WIDTH + 7) / 8) * 8,
  localparam int unsigned PDW   = (COORD_WIDTH > 32) ? 64 : 32,
  localparam int unsigned STEP  = (COORD_WIDTH > 32) ? 3 : 2,
  localparam int unsigned PAW   = STEP + RCI_IDX_W
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
  input  wire logic [IN_W-1:0]  s_axis_tdata,
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  // distance
  output logic [OUT_W-1:0]      m_axis_tdata,
  // hit
  output logic [0:0]            m_axis_tuser,
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [PAW-1:0]   paddr,
  input  wire logic [PDW-1:0]   pwdata,
  output logic [PDW-1:0]        prdata,
  output logic                  pready
);

  localparam int unsigned W   = COORD_WIDTH;
  localparam int unsigned F   = FRAC_BITS;
  localparam int unsigned KW  = W + 1;          // origin minus center
  localparam int unsigned W2  = 2 * W;
  localparam int unsigned AW  = 2 * W;          // a, unsigned
  localparam int unsigned BW  = 2 * W + 3;      // b and c, signed
  localparam int unsigned MW  = 2 * W + 2;      // magnitudes of a, b, c
  localparam int unsigned HW  = MW / 2;         // partial product split
  localparam int unsigned PW  = 2 * HW;
  localparam int unsigned SQW = 2 * MW;         // b^2 and a*c
  localparam int unsigned DSW = 2 * MW + 4;     // discriminant, signed
  localparam int unsigned RB  = MW + 2;         // square root bits
  localparam int unsigned RMW = 2 * RB + 1;     // root remainder
  localparam int unsigned NBW = RB + 2;         // -b +- s, signed
  localparam int unsigned NMW = RB + 1 + F;     // numerator magnitude
  localparam int unsigned DNW = AW + 1;         // 2a
  localparam int unsigned RW  = DNW + W;
  localparam int unsigned XW  = (NMW > RW) ? NMW : RW;
  localparam int unsigned YW  = 2 * W + F + 2;  // scaled y

  // ---------------------------------------------------------------
  // configuration registers
  logic signed [W-1:0] cx_q, cy_q, cz_q;
  logic [W-2:0]        rad_q, fh_q, md_q;
  logic [RCI_IDX_W-1:0] cfg_idx;
  logic                 cfg_wr;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[PAW-1:STEP];
  assign cfg_wr  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q  <= '0;
      cy_q  <= '0;
      cz_q  <= '0;
      rad_q <= (W-1)'(1) << F;
      fh_q  <= (W-1)'(2) << F;
      md_q  <= (W-1)'(RCI_MIN_DIST_RST);
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_CENTER_X:     cx_q  <= pwdata[W-1:0];
        REG_CENTER_Y:     cy_q  <= pwdata[W-1:0];
        REG_CENTER_Z:     cz_q  <= pwdata[W-1:0];
        REG_RADIUS:       rad_q <= pwdata[W-2:0];
        REG_FULL_HEIGHT:  fh_q  <= pwdata[W-2:0];
        REG_MIN_DISTANCE: md_q  <= pwdata[W-2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_CENTER_X:     prdata = PDW'($unsigned(cx_q));
      REG_CENTER_Y:     prdata = PDW'($unsigned(cy_q));
      REG_CENTER_Z:     prdata = PDW'($unsigned(cz_q));
      REG_RADIUS:       prdata = PDW'(rad_q);
      REG_FULL_HEIGHT:  prdata = PDW'(fh_q);
      REG_MIN_DISTANCE: prdata = PDW'(md_q);
      default:          prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------
  // global advance: the pipeline moves unless the output is held
  logic en, out_vld_q;
  assign en            = ~out_vld_q | m_axis_tready;
  assign s_axis_tready = en;

  // stage valid bits for the setup section
  logic [4:0] v_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= '0;
    else if (en) v_q <= {v_q[3:0], s_axis_tvalid};
  end

  // S0: offsets from the center
  logic signed [KW-1:0] kx0_q, ky0_q, kz0_q;
  logic signed [W-1:0]  dx0_q, dy0_q, dz0_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      kx0_q <= KW'($signed(s_axis_tdata[W-1:0]))     - KW'(cx_q);
      ky0_q <= KW'($signed(s_axis_tdata[2*W-1:W]))   - KW'(cy_q);
      kz0_q <= KW'($signed(s_axis_tdata[3*W-1:2*W])) - KW'(cz_q);
      dx0_q <= s_axis_tdata[4*W-1:3*W];
      dy0_q <= s_axis_tdata[5*W-1:4*W];
      dz0_q <= s_axis_tdata[6*W-1:5*W];
    end
  end

  // S1: squares and cross products
  logic signed [W2-1:0]     dxx_q, dzz_q;
  logic signed [W+KW-1:0]   dxk_q, dzk_q;
  logic signed [2*KW-1:0]   kxx_q, kzz_q;
  logic [2*W-3:0]           rr_q;
  logic signed [KW-1:0]     ky1_q;
  logic signed [W-1:0]      dy1_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      dxx_q <= W2'(dx0_q) * W2'(dx0_q);
      dzz_q <= W2'(dz0_q) * W2'(dz0_q);
      dxk_q <= (W+KW)'(dx0_q) * (W+KW)'(kx0_q);
      dzk_q <= (W+KW)'(dz0_q) * (W+KW)'(kz0_q);
      kxx_q <= (2*KW)'(kx0_q) * (2*KW)'(kx0_q);
      kzz_q <= (2*KW)'(kz0_q) * (2*KW)'(kz0_q);
      rr_q  <= (2*W-2)'(rad_q) * (2*W-2)'(rad_q);
      ky1_q <= ky0_q;
      dy1_q <= dy0_q;
    end
  end

  // S2: quadratic coefficients
  logic [AW-1:0]        a_d, a2_q;
  logic signed [BW-1:0] b2_q, c2_q;
  logic                 az2_q;
  logic signed [KW-1:0] ky2_q;
  logic signed [W-1:0]  dy2_q;
  assign a_d = $unsigned(dxx_q) + $unsigned(dzz_q);
  always_ff @(posedge clk_i) begin
    if (en) begin
      a2_q  <= a_d;
      az2_q <= (a_d == '0);
      b2_q  <= (BW'(dxk_q) + BW'(dzk_q)) <<< 1;
      c2_q  <= BW'(kxx_q) + BW'(kzz_q) - BW'($signed({1'b0, rr_q}));
      ky2_q <= ky1_q;
      dy2_q <= dy1_q;
    end
  end

  // S3: split magnitudes into halves, partial products of b*b and a*c
  logic [MW-1:0] bm, cm, am;
  assign bm = b2_q[BW-1] ? MW'(-b2_q) : MW'(b2_q);
  assign cm = c2_q[BW-1] ? MW'(-c2_q) : MW'(c2_q);
  assign am = MW'(a2_q);

  logic [PW-1:0]        bll_q, blh_q, bhh_q, acll_q, aclh_q, achl_q, achh_q;
  logic                 cneg3_q, az3_q;
  logic [AW-1:0]        a3_q;
  logic signed [BW-1:0] b3_q;
  logic signed [KW-1:0] ky3_q;
  logic signed [W-1:0]  dy3_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      bll_q   <= PW'(bm[HW-1:0])     * PW'(bm[HW-1:0]);
      blh_q   <= PW'(bm[HW-1:0])     * PW'(bm[MW-1:HW]);
      bhh_q   <= PW'(bm[MW-1:HW])    * PW'(bm[MW-1:HW]);
      acll_q  <= PW'(am[HW-1:0])     * PW'(cm[HW-1:0]);
      aclh_q  <= PW'(am[HW-1:0])     * PW'(cm[MW-1:HW]);
      achl_q  <= PW'(am[MW-1:HW])    * PW'(cm[HW-1:0]);
      achh_q  <= PW'(am[MW-1:HW])    * PW'(cm[MW-1:HW]);
      cneg3_q <= c2_q[BW-1];
      az3_q   <= az2_q;
      a3_q    <= a2_q;
      b3_q    <= b2_q;
      ky3_q   <= ky2_q;
      dy3_q   <= dy2_q;
    end
  end

  // S4: recombine partial products
  logic [SQW-1:0]       bsq4_q, ac4_q;
  logic                 cneg4_q, az4_q;
  logic [AW-1:0]        a4_q;
  logic signed [BW-1:0] b4_q;
  logic signed [KW-1:0] ky4_q;
  logic signed [W-1:0]  dy4_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      bsq4_q  <= (SQW'(bhh_q) << (2*HW)) + (SQW'(blh_q) << (HW+1)) + SQW'(bll_q);
      ac4_q   <= (SQW'(achh_q) << (2*HW)) + ((SQW'(aclh_q) + SQW'(achl_q)) << HW)
                 + SQW'(acll_q);
      cneg4_q <= cneg3_q;
      az4_q   <= az3_q;
      a4_q    <= a3_q;
      b4_q    <= b3_q;
      ky4_q   <= ky3_q;
      dy4_q   <= dy3_q;
    end
  end

  // S5: discriminant, then square root, one root bit per stage
  logic signed [DSW-1:0] disc, ac4x;
  assign ac4x = $signed(DSW'(ac4_q) << 2);
  assign disc = $signed(DSW'(bsq4_q)) - (cneg4_q ? -ac4x : ac4x);

  logic [RMW-1:0]        sq_rem_q  [0:RB];
  logic [RB-1:0]         sq_root_q [0:RB];
  logic                  sq_miss_q [0:RB];
  logic [AW-1:0]         sq_a_q    [0:RB];
  logic signed [BW-1:0]  sq_b_q    [0:RB];
  logic signed [KW-1:0]  sq_ky_q   [0:RB];
  logic signed [W-1:0]   sq_dy_q   [0:RB];
  logic [RB:0]           sq_v_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_rem_q[0]  <= disc[DSW-1] ? '0 : RMW'($unsigned(disc[DSW-2:0]));
      sq_root_q[0] <= '0;
      sq_miss_q[0] <= az4_q | disc[DSW-1];
      sq_a_q[0]    <= a4_q;
      sq_b_q[0]    <= b4_q;
      sq_ky_q[0]   <= ky4_q;
      sq_dy_q[0]   <= dy4_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) sq_v_q <= '0;
    else if (en) sq_v_q <= {sq_v_q[RB-1:0], v_q[4]};
  end

  for (genvar j = 0; j < RB; j++) begin : g_sqrt
    localparam int unsigned BIT = RB - 1 - j;
    logic [RMW-1:0] cand;
    // (root + 2^bit)^2 - root^2
    assign cand = (RMW'(sq_root_q[j]) << (BIT + 1)) + (RMW'(1) << (2 * BIT));
    always_ff @(posedge clk_i) begin
      if (en) begin
        if (sq_rem_q[j] >= cand) begin
          sq_rem_q[j+1]  <= sq_rem_q[j] - cand;
          sq_root_q[j+1] <= sq_root_q[j] | (RB'(1) << BIT);
        end else begin
          sq_rem_q[j+1]  <= sq_rem_q[j];
          sq_root_q[j+1] <= sq_root_q[j];
        end
        sq_miss_q[j+1] <= sq_miss_q[j];
        sq_a_q[j+1]    <= sq_a_q[j];
        sq_b_q[j+1]    <= sq_b_q[j];
        sq_ky_q[j+1]   <= sq_ky_q[j];
        sq_dy_q[j+1]   <= sq_dy_q[j];
      end
    end
  end

  // numerators (-b -+ s) scaled by 2^F, split into sign and magnitude
  logic signed [NBW-1:0] nb, n1, n2, n1m, n2m;
  assign nb  = -NBW'(sq_b_q[RB]);
  assign n1  = nb - $signed(NBW'(sq_root_q[RB]));
  assign n2  = nb + $signed(NBW'(sq_root_q[RB]));
  assign n1m = n1[NBW-1] ? -n1 : n1;
  assign n2m = n2[NBW-1] ? -n2 : n2;

  // dividers: index 0 holds the numerators, then one quotient bit a stage
  logic [XW-1:0]         dv_r1_q  [0:W];
  logic [XW-1:0]         dv_r2_q  [0:W];
  logic [W-1:0]          dv_q1_q  [0:W];
  logic [W-1:0]          dv_q2_q  [0:W];
  logic                  dv_s1_q  [0:W];
  logic                  dv_s2_q  [0:W];
  logic                  dv_o1_q  [0:W];
  logic                  dv_o2_q  [0:W];
  logic [DNW-1:0]        dv_den_q [0:W];
  logic                  dv_miss_q[0:W];
  logic signed [KW-1:0]  dv_ky_q  [0:W];
  logic signed [W-1:0]   dv_dy_q  [0:W];
  logic [W:0]            dv_v_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      dv_r1_q[0]   <= XW'({n1m[NBW-2:0], {F{1'b0}}});
      dv_r2_q[0]   <= XW'({n2m[NBW-2:0], {F{1'b0}}});
      dv_q1_q[0]   <= '0;
      dv_q2_q[0]   <= '0;
      dv_s1_q[0]   <= n1[NBW-1];
      dv_s2_q[0]   <= n2[NBW-1];
      dv_o1_q[0]   <= 1'b0;
      dv_o2_q[0]   <= 1'b0;
      dv_den_q[0]  <= {sq_a_q[RB], 1'b0};
      dv_miss_q[0] <= sq_miss_q[RB];
      dv_ky_q[0]   <= sq_ky_q[RB];
      dv_dy_q[0]   <= sq_dy_q[RB];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) dv_v_q <= '0;
    else if (en) dv_v_q <= {dv_v_q[W-1:0], sq_v_q[RB]};
  end

  for (genvar j = 0; j < W; j++) begin : g_div
    localparam int unsigned BIT = W - 1 - j;
    logic [XW-1:0] dsh;
    logic          o1, o2;
    assign dsh = XW'(dv_den_q[j]) << BIT;
    // quotient overflows W bits: checked once, on entry
    if (j == 0) begin : g_ovf
      assign o1 = (dv_r1_q[0] >> W) >= XW'(dv_den_q[0]);
      assign o2 = (dv_r2_q[0] >> W) >= XW'(dv_den_q[0]);
    end else begin : g_keep
      assign o1 = dv_o1_q[j];
      assign o2 = dv_o2_q[j];
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        if (dv_r1_q[j] >= dsh) begin
          dv_r1_q[j+1] <= dv_r1_q[j] - dsh;
          dv_q1_q[j+1] <= dv_q1_q[j] | (W'(1) << BIT);
        end else begin
          dv_r1_q[j+1] <= dv_r1_q[j];
          dv_q1_q[j+1] <= dv_q1_q[j];
        end
        if (dv_r2_q[j] >= dsh) begin
          dv_r2_q[j+1] <= dv_r2_q[j] - dsh;
          dv_q2_q[j+1] <= dv_q2_q[j] | (W'(1) << BIT);
        end else begin
          dv_r2_q[j+1] <= dv_r2_q[j];
          dv_q2_q[j+1] <= dv_q2_q[j];
        end
        dv_o1_q[j+1]   <= o1;
        dv_o2_q[j+1]   <= o2;
        dv_s1_q[j+1]   <= dv_s1_q[j];
        dv_s2_q[j+1]   <= dv_s2_q[j];
        dv_den_q[j+1]  <= dv_den_q[j];
        dv_miss_q[j+1] <= dv_miss_q[j];
        dv_ky_q[j+1]   <= dv_ky_q[j];
        dv_dy_q[j+1]   <= dv_dy_q[j];
      end
    end
  end

  // floor toward minus infinity and clamp to the coordinate range
  function automatic logic [W-1:0] fix_root(input logic [W-1:0] q, input logic neg,
                                            input logic ovf, input logic exact);
    logic [W:0] qq, lim;
    qq  = {1'b0, q} + (W+1)'(!exact);
    lim = (W+1)'(1) << (W - 1);
    if (!neg) begin
      fix_root = (ovf || q[W-1]) ? {1'b0, {(W-1){1'b1}}} : q;
    end else begin
      fix_root = (ovf || (qq > lim)) ? {1'b1, {(W-1){1'b0}}} : W'(-qq);
    end
  endfunction

  logic signed [W-1:0]  t1f_q, t2f_q, dyf_q;
  logic signed [KW-1:0] kyf_q;
  logic                 missf_q, vf_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      t1f_q   <= fix_root(dv_q1_q[W], dv_s1_q[W], dv_o1_q[W], dv_r1_q[W] == '0);
      t2f_q   <= fix_root(dv_q2_q[W], dv_s2_q[W], dv_o2_q[W], dv_r2_q[W] == '0);
      dyf_q   <= dv_dy_q[W];
      kyf_q   <= dv_ky_q[W];
      missf_q <= dv_miss_q[W];
    end
  end

  // scaled y of both roots
  logic signed [W2-1:0] p1, p2;
  assign p1 = W2'(t1f_q) * W2'(dyf_q);
  assign p2 = W2'(t2f_q) * W2'(dyf_q);

  logic signed [YW-1:0] y1_q, y2_q;
  logic signed [W-1:0]  t1y_q, t2y_q;
  logic                 missy_q, vy_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      y1_q    <= (YW'(kyf_q) <<< F) + YW'(p1);
      y2_q    <= (YW'(kyf_q) <<< F) + YW'(p2);
      t1y_q   <= t1f_q;
      t2y_q   <= t2f_q;
      missy_q <= missf_q;
    end
  end

  // height window and root choice
  logic signed [YW-1:0] hs;
  logic signed [W:0]    md_s;
  logic                 in1, in2, ok1, ok2;
  assign hs   = $signed(YW'({fh_q[W-2:1], {F{1'b0}}}));
  assign in1  = (y1_q <= hs) && (y1_q >= -hs);
  assign in2  = (y2_q <= hs) && (y2_q >= -hs);
  assign md_s = $signed({2'b00, md_q});
  assign ok1  = (W+1)'(t1y_q) > md_s;
  assign ok2  = (W+1)'(t2y_q) > md_s;

  logic                hit_q;
  logic signed [W-1:0] dist_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      hit_q  <= ~missy_q & (in1 | in2) & (ok1 | ok2);
      dist_q <= (missy_q | ~(in1 | in2)) ? '0 : ok1 ? t1y_q : ok2 ? t2y_q : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vf_q      <= 1'b0;
      vy_q      <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      vf_q      <= dv_v_q[W];
      vy_q      <= vf_q;
      out_vld_q <= vy_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = hit_q;
  assign m_axis_tdata  = OUT_W'($unsigned(dist_q));

endmodule : ray_cylinder_intersect_unit

`default_nettype wire

### test/testbench.sv
// Self-checking testbench for ray_cylinder_intersect_unit: streams rays in,
// predicts hit and distance with exact wide integer math, and checks every result.
// Depends on rci_pkg and the unit itself.
`timescale 1ns / 1ps
`default_nettype none

module testbench;
  import rci_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned LATENCY     = 3 * RCI_COORD_WIDTH + 14;

  // exact intermediates; everything here fits well inside 256 bits
  typedef logic signed [255:0] wint_t;

  // field order matches tdata, origin_x in the lowest bits
  typedef struct packed {
    logic [31:0] dir_z;
    logic [31:0] dir_y;
    logic [31:0] dir_x;
    logic [31:0] origin_z;
    logic [31:0] origin_y;
    logic [31:0] origin_x;
  } ray_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] distance;
  } isect_t;

  logic          clk_i;
  logic          rst_ni;
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
  logic [191:0]  s_axis_tdata;
  logic          s_axis_tvalid;
  logic          s_axis_tready;
  // distance
  logic [31:0]   m_axis_tdata;
  // hit
  logic [0:0]    m_axis_tuser;
  logic          m_axis_tvalid;
  logic          m_axis_tready = 1'b0;
  logic          psel;
  logic          penable;
  logic          pwrite;
  logic [4:0]    paddr;
  logic [31:0]   pwdata;
  logic [31:0]   prdata;
  logic          pready;

  ray_cylinder_intersect_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // cylinder settings as the unit should hold them
  logic [31:0] cyl_cx, cyl_cy, cyl_cz;
  logic [30:0] cyl_radius, cyl_height, cyl_min_dist;

  isect_t      isect_q[$];
  int unsigned mismatches  = 0;
  int unsigned cycle_count = 0;
  int unsigned burst_left;
  int unsigned stall_mode  = 0;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // floor division by a positive value, clamped to the signed 32-bit range
  function automatic wint_t floor_div_clamp(input wint_t num, input wint_t den);
    wint_t q;
    q = num / den;
    if (num < 0 && q * den != num) q = q - 1;
    if (q > wint_t'(32'sh7fffffff)) q = wint_t'(32'sh7fffffff);
    if (q < -wint_t'(64'sh80000000)) q = -wint_t'(64'sh80000000);
    return q;
  endfunction

  function automatic logic y_inside(input wint_t ky, input wint_t dy, input wint_t t,
                                    input wint_t half_s);
    wint_t y;
    y = (ky <<< 16) + t * dy;
    return (y <= half_s) && (y >= -half_s);
  endfunction

  // expected intersection of one ray with the current cylinder
  function automatic isect_t cylinder_hit(input ray_t r);
    wint_t kx, ky, kz, dx, dy, dz, rad, a, b, c, disc, root, cand, t1, t2, half_s, md, t;
    isect_t res;
    res = '0;
    kx  = wint_t'($signed(r.origin_x)) - wint_t'($signed(cyl_cx));
    ky  = wint_t'($signed(r.origin_y)) - wint_t'($signed(cyl_cy));
    kz  = wint_t'($signed(r.origin_z)) - wint_t'($signed(cyl_cz));
    dx  = wint_t'($signed(r.dir_x));
    dy  = wint_t'($signed(r.dir_y));
    dz  = wint_t'($signed(r.dir_z));
    rad = wint_t'({1'b0, cyl_radius});
    a = dx * dx + dz * dz;
    if (a == 0) return res;
    b = 2 * (dx * kx + dz * kz);
    c = kx * kx + kz * kz - rad * rad;
    disc = b * b - 4 * a * c;
    if (disc < 0) return res;
    // discriminant stays below 2^140, so the root fits in 71 bits
    root = 0;
    for (int i = 70; i >= 0; i--) begin
      cand = root | (wint_t'(1) <<< i);
      if (cand * cand <= disc) root = cand;
    end
    t1 = floor_div_clamp((-b - root) <<< 16, 2 * a);
    t2 = floor_div_clamp((-b + root) <<< 16, 2 * a);
    half_s = wint_t'({1'b0, cyl_height >> 1}) <<< 16;
    if (!y_inside(ky, dy, t1, half_s) && !y_inside(ky, dy, t2, half_s)) return res;
    md = wint_t'({1'b0, cyl_min_dist});
    if (t1 > md) t = t1;
    else if (t2 > md) t = t2;
    else return res;
    res.hit = 1'b1;
    res.distance = t[31:0];
    return res;
  endfunction

  // one register write, setup then access; the unit is idle meanwhile
  task automatic write_reg(input logic [RCI_IDX_W-1:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_CENTER_X:     cyl_cx       = value;
      REG_CENTER_Y:     cyl_cy       = value;
      REG_CENTER_Z:     cyl_cz       = value;
      REG_RADIUS:       cyl_radius   = value[30:0];
      REG_FULL_HEIGHT:  cyl_height   = value[30:0];
      REG_MIN_DISTANCE: cyl_min_dist = value[30:0];
      default: ;
    endcase
    // idle cycle between transfers
    @(posedge clk_i);
  endtask

  task automatic write_cylinder(input logic [31:0] cx, input logic [31:0] cy,
                                input logic [31:0] cz, input logic [31:0] rad,
                                input logic [31:0] height, input logic [31:0] md);
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Y, cy);
    write_reg(REG_CENTER_Z, cz);
    write_reg(REG_RADIUS, rad);
    write_reg(REG_FULL_HEIGHT, height);
    write_reg(REG_MIN_DISTANCE, md);
  endtask

  // send one ray in bursts with random gaps; handshake sampled at the falling edge
  task automatic send_ray(input ray_t r);
    logic taken;
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    s_axis_tdata  <= r;
    s_axis_tvalid <= 1'b1;
    do begin
      @(negedge clk_i);
      taken = s_axis_tready;
      @(posedge clk_i);
    end while (!taken);
    isect_q.push_back(cylinder_hit(r));
  endtask

  // stop sending and let every outstanding ray come back
  task automatic drain;
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (isect_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
  endtask

  function automatic logic [31:0] fx(input int v);
    return v <<< 16;
  endfunction

  function automatic ray_t make_ray(input int ox, input int oy, input int oz,
                                    input int dx, input int dy, input int dz);
    ray_t r;
    r = {dz, dy, dx, oz, oy, ox};
    return r;
  endfunction

  function automatic ray_t noise_ray;
    ray_t r;
    r = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
    return r;
  endfunction

  // ray that starts near the cylinder and heads roughly at its axis
  function automatic ray_t aimed_ray;
    int offx, offy, offz, sh;
    ray_t r;
    offx = int'($urandom_range(0, 1 << 23)) - (1 << 22);
    offy = int'($urandom_range(0, 1 << 19)) - (1 << 18);
    offz = int'($urandom_range(0, 1 << 23)) - (1 << 22);
    sh   = $urandom_range(0, 6);
    r.origin_x = $signed(cyl_cx) + offx;
    r.origin_y = $signed(cyl_cy) + offy;
    r.origin_z = $signed(cyl_cz) + offz;
    r.dir_x = (-offx + int'($urandom_range(0, 1 << 18)) - (1 << 17)) >>> sh;
    r.dir_y = (int'($urandom_range(0, 1 << 18)) - (1 << 17)) >>> sh;
    r.dir_z = (-offz + int'($urandom_range(0, 1 << 18)) - (1 << 17)) >>> sh;
    return r;
  endfunction

  // hand-picked rays under the reset cylinder, then field extremes
  task automatic test_directed_rays;
    send_ray(make_ray(fx(-5), 0, 0, fx(1), 0, 0));          // straight hit, t = 4
    send_ray(make_ray(fx(-5), 0, fx(1), fx(1), 0, 0));      // grazing, zero discriminant
    send_ray(make_ray(fx(-5), 0, fx(5), fx(1), 0, 0));      // negative discriminant
    send_ray(make_ray(0, 0, 0, 0, fx(1), 0));               // parallel to the axis
    send_ray(make_ray(0, 0, 0, 0, 0, 0));                   // zero direction
    send_ray(make_ray(fx(-5), fx(5), 0, fx(1), 0, 0));      // above the top
    send_ray(make_ray(fx(-5), fx(1), 0, fx(1), 0, 0));      // on the top rim
    send_ray(make_ray(fx(-5), -fx(1), 0, fx(1), 0, 0));     // on the bottom rim
    send_ray(make_ray(fx(-5), fx(3), 0, fx(1), -fx(1), 0)); // enters from above
    send_ray(make_ray(0, 0, 0, fx(1), 0, fx(1)));           // origin inside
    send_ray(make_ray(fx(5), 0, 0, fx(1), 0, 0));           // cylinder behind
    send_ray(make_ray(fx(1), 0, 0, fx(1), 0, 0));           // starts on the wall
    send_ray(make_ray(-fx(30000), 0, 0, 1, 0, 0));          // distance clamps high
    send_ray(make_ray(fx(30000), 0, 0, 1, 0, 0));           // far root clamps low
    send_ray(make_ray(-fx(1) - 40, 0, 0, 1, 0, 0));         // near root at t = 40
    send_ray({6{32'h7fffffff}});
    send_ray({6{32'h80000000}});
    send_ray({6{32'hffffffff}});
    send_ray({6{32'h00000001}});
    send_ray(make_ray(32'h80000000, 0, 32'h7fffffff, 32'h7fffffff, 0, 32'h80000000));
  endtask

  // extreme register settings, each phase preceded by a full drain
  task automatic test_register_extremes;
    drain;
    write_cylinder(32'h7fffffff, 32'h80000000, 32'h7fffffff,
                   32'h7fffffff, 32'h7fffffff, 32'h0);
    for (int i = 0; i < 30; i++) send_ray(($urandom_range(0, 1) != 0) ? noise_ray() : aimed_ray());
    drain;
    write_cylinder(32'h80000000, 32'h7fffffff, 32'h80000000,
                   32'h0, 32'h0, 32'h7fffffff);
    for (int i = 0; i < 30; i++) send_ray(($urandom_range(0, 1) != 0) ? noise_ray() : aimed_ray());
    drain;
    // upper bits beyond the unsigned registers must be dropped
    write_cylinder(0, 0, 0, 32'h80010000, 32'hffffffff, 32'h80000000);
    for (int i = 0; i < 30; i++) send_ray(aimed_ray());
  endtask

  // random cylinders, mostly aimed rays with some raw noise
  task automatic test_random_scenes;
    for (int ph = 0; ph < 7; ph++) begin
      drain;
      write_cylinder(int'($urandom_range(0, 1 << 21)) - (1 << 20),
                     int'($urandom_range(0, 1 << 21)) - (1 << 20),
                     int'($urandom_range(0, 1 << 21)) - (1 << 20),
                     $urandom_range(1 << 14, 1 << 22),
                     $urandom_range(1 << 15, 1 << 22),
                     $urandom_range(0, 1 << 16));
      for (int i = 0; i < 120; i++)
        send_ray(($urandom_range(0, 9) < 7) ? aimed_ray() : noise_ray());
    end
  endtask

  // receiver stall pattern: a randomly drawn mode sets tready (always, random, or mostly stalled)
  always @(posedge clk_i) begin
    if (cycle_count % 64 == 0) stall_mode = $urandom_range(0, 2);
    case (stall_mode)
      0:       m_axis_tready <= 1'b1;
      1:       m_axis_tready <= 1'($urandom_range(0, 1));
      default: m_axis_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // result check; the transfer completes at the next rising edge
  always @(negedge clk_i) begin
    isect_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (isect_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: hit=%0b distance=%h", m_axis_tuser, m_axis_tdata);
      end else begin
        want = isect_q.pop_front();
        if (m_axis_tuser[0] !== want.hit || m_axis_tdata !== want.distance) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected hit=%0b distance=%h, got hit=%0b distance=%h",
                     want.hit, want.distance, m_axis_tuser, m_axis_tdata);
        end
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tvalid = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    burst_left    = 0;
    cyl_cx        = '0;
    cyl_cy        = '0;
    cyl_cz        = '0;
    cyl_radius    = 31'(1 << RCI_FRAC_BITS);
    cyl_height    = 31'(2 << RCI_FRAC_BITS);
    cyl_min_dist  = 31'(RCI_MIN_DIST_RST);
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_rays;
    test_register_extremes;
    test_random_scenes;
    drain;

    if (mismatches == 0 && isect_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire
